// ----- rtl/led_blink_indicator_unit_defines.svh -----
// Assertion helpers for the LED blink indicator. They expect clk_i and rst_ni in scope.
`ifndef LED_BLINK_INDICATOR_UNIT_DEFINES_SVH
`define LED_BLINK_INDICATOR_UNIT_DEFINES_SVH

`define LBI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define LBI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/lbi_pkg.sv -----
package lbi_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgW  = 16;
  localparam int unsigned PerW  = CfgW + 1;
  localparam int unsigned CntW  = $clog2(TimeW);
  localparam int unsigned IdxW  = 3;

  localparam logic [CfgW-1:0] SlowOnRst   = 16'd700;
  localparam logic [CfgW-1:0] SlowOffRst  = 16'd300;
  localparam logic [CfgW-1:0] FastOnRst   = 16'd150;
  localparam logic [CfgW-1:0] FastOffRst  = 16'd150;
  localparam logic [CfgW-1:0] BurstDurRst = 16'd1800;
  localparam logic [CfgW-1:0] FlashDurRst = 16'd100;

  typedef enum logic [IdxW-1:0] {
    CFG_SLOW_ON   = 3'd0,
    CFG_SLOW_OFF  = 3'd1,
    CFG_FAST_ON   = 3'd2,
    CFG_FAST_OFF  = 3'd3,
    CFG_BURST_DUR = 3'd4,
    CFG_FLASH_DUR = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_SET   = 2'd1,
    OP_BURST = 2'd2,
    OP_FLASH = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_ON   = 2'd1,
    MODE_SLOW = 2'd2,
    MODE_FAST = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EVAL = 2'd1,
    ST_DIV  = 2'd2,
    ST_RESP = 2'd3
  } state_e;

endpackage

// ----- rtl/lbi_if.sv -----
interface lbi_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [1:0] new_mode;

  modport source (output valid, operation, new_mode, input ready);
  modport sink   (input valid, operation, new_mode, output ready);
endinterface

interface lbi_rsp_if;
  logic valid;
  logic ready;
  logic led_on;

  modport source (output valid, led_on, input ready);
  modport sink   (input valid, led_on, output ready);
endinterface

// ----- rtl/led_blink_indicator_unit.sv -----
// LED indicator with off, on, slow blink and fast blink modes, plus a notification burst and a
// single inverted flash laid over them. Each request is a 1 ms tick, a mode change or an overlay
// trigger, and each returns the LED level after it; blink mode changes and triggers keep the level
// until the next tick. Mode changes and triggers go from acceptance straight to the response state.
// A tick passes through the evaluation state; one that needs a blink phase then runs a bit-serial
// remainder unit that retires one bit of the 32-bit elapsed time per cycle. The response is
// presented in the same cycle as the block is ready again. The block takes no new request while
// one is in work; a finished response may still wait at the output, and a stalled output holds
// the next response and the block with it.
`include "led_blink_indicator_unit_defines.svh"

module led_blink_indicator_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [lbi_pkg::IdxW-1:0]  cfg_idx_i,
  input  logic [lbi_pkg::CfgW-1:0]  cfg_wdata_i,
  lbi_req_if.sink                   req_i,
  lbi_rsp_if.source                 rsp_o
);
  import lbi_pkg::*;

  state_e state_q, state_d;

  logic [CfgW-1:0] slow_on_q, slow_off_q, fast_on_q, fast_off_q, burst_dur_q, flash_dur_q;

  logic [TimeW-1:0] now_q, slow_start_q, fast_start_q, burst_start_q, flash_start_q;
  logic             slow_started_q, fast_started_q, burst_active_q, flash_active_q;
  mode_e            mode_q;
  logic             level_q;
  logic             out_valid_q, out_led_q;

  logic [TimeW-1:0] dvd_q;
  logic [PerW-1:0]  rem_q, div_q;
  logic [CfgW-1:0]  on_q;
  logic [CntW-1:0]  cnt_q;

  logic             req_fire, resp_load;
  op_e              req_op;
  mode_e            req_mode;

  logic [TimeW-1:0] start_sel, elapsed;
  logic [CfgW-1:0]  dur_sel, on_sel, off_sel;
  logic [PerW-1:0]  period;
  logic             expired, base_lvl;
  logic             eval_div, eval_lvl, eval_clr_burst, eval_clr_flash;

  logic [PerW:0]    trial;
  logic [PerW-1:0]  rem_next;
  logic             div_last;

  assign req_op   = op_e'(req_i.operation);
  assign req_mode = mode_e'(req_i.new_mode);
  assign req_fire = req_i.valid && req_i.ready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          state_d = (req_op == OP_TICK) ? ST_EVAL : ST_RESP;
        end
      end
      ST_EVAL: begin
        state_d = eval_div ? ST_DIV : ST_RESP;
      end
      ST_DIV: begin
        if (div_last) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (resp_load) begin
          state_d = ST_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    req_i.ready  = (state_q == ST_IDLE);
    rsp_o.valid  = out_valid_q;
    rsp_o.led_on = out_led_q;
    resp_load    = (state_q == ST_RESP) && (!out_valid_q || rsp_o.ready);
    div_last     = (state_q == ST_DIV) && (cnt_q == {CntW{1'b1}});
  end

  // Overlay and blink evaluation after a tick.
  always_comb begin
    base_lvl = (mode_q == MODE_ON);
    if (burst_active_q) begin
      start_sel = burst_start_q;
    end else if (flash_active_q) begin
      start_sel = flash_start_q;
    end else if (mode_q == MODE_SLOW) begin
      start_sel = slow_start_q;
    end else begin
      start_sel = fast_start_q;
    end
    dur_sel = burst_active_q ? burst_dur_q : flash_dur_q;
    elapsed = now_q - start_sel;
    expired = elapsed > {{(TimeW-CfgW){1'b0}}, dur_sel};
    on_sel  = (!burst_active_q && !flash_active_q && mode_q == MODE_SLOW) ? slow_on_q : fast_on_q;
    off_sel = (!burst_active_q && !flash_active_q && mode_q == MODE_SLOW) ? slow_off_q : fast_off_q;
    period  = {1'b0, on_sel} + {1'b0, off_sel};

    eval_div       = 1'b0;
    eval_lvl       = base_lvl;
    eval_clr_burst = 1'b0;
    eval_clr_flash = 1'b0;
    if (burst_active_q) begin
      if (expired) begin
        eval_clr_burst = 1'b1;
      end else begin
        eval_div = (period != '0);
        eval_lvl = 1'b0;
      end
    end else if (flash_active_q) begin
      if (expired) begin
        eval_clr_flash = 1'b1;
      end else begin
        eval_lvl = !base_lvl;
      end
    end else if (mode_q == MODE_SLOW || mode_q == MODE_FAST) begin
      eval_div = (period != '0);
      eval_lvl = 1'b0;
    end
  end

  always_comb begin
    trial = {rem_q, dvd_q[TimeW-1]};
    if (trial >= {1'b0, div_q}) begin
      rem_next = PerW'(trial - {1'b0, div_q});
    end else begin
      rem_next = trial[PerW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      slow_on_q      <= SlowOnRst;
      slow_off_q     <= SlowOffRst;
      fast_on_q      <= FastOnRst;
      fast_off_q     <= FastOffRst;
      burst_dur_q    <= BurstDurRst;
      flash_dur_q    <= FlashDurRst;
      now_q          <= '0;
      mode_q         <= MODE_OFF;
      slow_start_q   <= '0;
      fast_start_q   <= '0;
      burst_start_q  <= '0;
      flash_start_q  <= '0;
      slow_started_q <= 1'b0;
      fast_started_q <= 1'b0;
      burst_active_q <= 1'b0;
      flash_active_q <= 1'b0;
      level_q        <= 1'b0;
      out_valid_q    <= 1'b0;
      out_led_q      <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SLOW_ON:   slow_on_q   <= cfg_wdata_i;
          CFG_SLOW_OFF:  slow_off_q  <= cfg_wdata_i;
          CFG_FAST_ON:   fast_on_q   <= cfg_wdata_i;
          CFG_FAST_OFF:  fast_off_q  <= cfg_wdata_i;
          CFG_BURST_DUR: burst_dur_q <= cfg_wdata_i;
          CFG_FLASH_DUR: flash_dur_q <= cfg_wdata_i;
          default: ;
        endcase
      end

      if (req_fire) begin
        unique case (req_op)
          OP_TICK: now_q <= now_q + 1'b1;
          OP_SET: begin
            mode_q <= req_mode;
            unique case (req_mode)
              MODE_ON:  level_q <= 1'b1;
              MODE_OFF: level_q <= 1'b0;
              MODE_SLOW: begin
                if (!slow_started_q) begin
                  slow_start_q   <= now_q;
                  slow_started_q <= 1'b1;
                end
              end
              MODE_FAST: begin
                if (!fast_started_q) begin
                  fast_start_q   <= now_q;
                  fast_started_q <= 1'b1;
                end
              end
            endcase
          end
          OP_BURST: begin
            burst_start_q  <= now_q;
            burst_active_q <= 1'b1;
          end
          OP_FLASH: begin
            flash_start_q  <= now_q;
            flash_active_q <= 1'b1;
          end
        endcase
      end

      if (state_q == ST_EVAL) begin
        level_q <= eval_lvl;
        if (eval_clr_burst) begin
          burst_active_q <= 1'b0;
        end
        if (eval_clr_flash) begin
          flash_active_q <= 1'b0;
        end
      end

      if (div_last) begin
        level_q <= (rem_next < {1'b0, on_q});
      end

      if (resp_load) begin
        out_valid_q <= 1'b1;
        out_led_q   <= level_q;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Serial remainder unit: one quotient bit per cycle.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_EVAL) begin
      dvd_q <= elapsed;
      rem_q <= '0;
      div_q <= period;
      on_q  <= on_sel;
      cnt_q <= '0;
    end else if (state_q == ST_DIV) begin
      dvd_q <= {dvd_q[TimeW-2:0], 1'b0};
      rem_q <= rem_next;
      cnt_q <= cnt_q + 1'b1;
    end
  end

  `LBI_ASSERT_NXT(a_busy_after_accept, req_fire, !req_i.ready, "block took a second request")
  `LBI_ASSERT_IMP(a_rem_below_div, state_q == ST_DIV, rem_q < div_q, "remainder not below period")
  `LBI_ASSERT_IMP(a_burst_end_on_eval, $fell(burst_active_q), $past(state_q) == ST_EVAL,
                  "burst ended outside a tick evaluation")
  `LBI_ASSERT_IMP(a_started_sticky, 1'b1, !$fell(slow_started_q) && !$fell(fast_started_q),
                  "blink start stamp was cleared")
  `LBI_ASSERT_NXT(a_resp_follows, resp_load, rsp_o.valid && state_q == ST_IDLE,
                  "response not presented after load")

endmodule
